@@ sv/sha256_byte_stream_hasher_unit_macros.svh @@
// Assertion macros used by the hasher control module.
// Each expects signals named clk and arst_n in the module that uses it.
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBSH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBSH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/sbsh_pkg.sv @@
`default_nettype none

package sbsh_pkg;

	localparam int unsigned FILL_W = 6;
	localparam int unsigned ROUND_W = 6;
	localparam int unsigned COUNT_W = 61;
	localparam int unsigned BLOCK_W = 512;
	localparam int unsigned DIGEST_W = 256;

	localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
	localparam logic [FILL_W-1:0] FILL_LEN = 6'd56;
	localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] INIT_WORDS [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD_MARK,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_COMP,
		ST_FOLD,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		SEL_MSG,
		SEL_MARK,
		SEL_ZERO,
		SEL_LEN
	} byte_sel_t;

	typedef struct packed {
		logic shift_en;
		byte_sel_t byte_sel;
		logic count_byte;
		logic comp_start;
		logic round_en;
		logic [ROUND_W-1:0] round;
		logic fold;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic out_free;
	} sts_t;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
	endfunction

endpackage

`default_nettype wire

@@ sv/sbsh_ctrl.sv @@
`default_nettype none

`include "sha256_byte_stream_hasher_unit_macros.svh"

module sbsh_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_present,
	input  wire logic           in_last,
	output logic                in_ready,
	input  wire sbsh_pkg::sts_t sts,
	output sbsh_pkg::cmd_t      cmd
);

	sbsh_pkg::state_t state_q, state_d;
	sbsh_pkg::state_t ret_q, ret_d;
	logic [sbsh_pkg::ROUND_W-1:0] round_q;
	logic fill_last;

	assign fill_last = (sts.fill == sbsh_pkg::FILL_LAST);

	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		case (state_q)
			sbsh_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_present && fill_last) begin
						state_d = sbsh_pkg::ST_COMP;
						ret_d = in_last ? sbsh_pkg::ST_PAD_MARK : sbsh_pkg::ST_IDLE;
					end else if (in_last) begin
						state_d = sbsh_pkg::ST_PAD_MARK;
					end
				end
			end
			sbsh_pkg::ST_PAD_MARK: begin
				if (fill_last) begin
					state_d = sbsh_pkg::ST_COMP;
					ret_d = sbsh_pkg::ST_PAD_ZERO;
				end else begin
					state_d = sbsh_pkg::ST_PAD_ZERO;
				end
			end
			sbsh_pkg::ST_PAD_ZERO: begin
				if (sts.fill == sbsh_pkg::FILL_LEN) begin
					state_d = sbsh_pkg::ST_PAD_LEN;
				end else if (fill_last) begin
					state_d = sbsh_pkg::ST_COMP;
					ret_d = sbsh_pkg::ST_PAD_ZERO;
				end
			end
			sbsh_pkg::ST_PAD_LEN: begin
				if (fill_last) begin
					state_d = sbsh_pkg::ST_COMP;
					ret_d = sbsh_pkg::ST_DONE;
				end
			end
			sbsh_pkg::ST_COMP: begin
				if (round_q == sbsh_pkg::ROUND_LAST) begin
					state_d = sbsh_pkg::ST_FOLD;
				end
			end
			sbsh_pkg::ST_FOLD: begin
				state_d = ret_q;
			end
			sbsh_pkg::ST_DONE: begin
				if (sts.out_free) begin
					state_d = sbsh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sbsh_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		cmd.byte_sel = sbsh_pkg::SEL_MSG;
		cmd.round = round_q;
		case (state_q)
			sbsh_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_present) begin
					cmd.shift_en = 1'b1;
					cmd.count_byte = 1'b1;
					cmd.comp_start = fill_last;
				end
			end
			sbsh_pkg::ST_PAD_MARK: begin
				cmd.shift_en = 1'b1;
				cmd.byte_sel = sbsh_pkg::SEL_MARK;
				cmd.comp_start = fill_last;
			end
			sbsh_pkg::ST_PAD_ZERO: begin
				if (sts.fill != sbsh_pkg::FILL_LEN) begin
					cmd.shift_en = 1'b1;
					cmd.byte_sel = sbsh_pkg::SEL_ZERO;
					cmd.comp_start = fill_last;
				end
			end
			sbsh_pkg::ST_PAD_LEN: begin
				cmd.shift_en = 1'b1;
				cmd.byte_sel = sbsh_pkg::SEL_LEN;
				cmd.comp_start = fill_last;
			end
			sbsh_pkg::ST_COMP: begin
				cmd.round_en = 1'b1;
			end
			sbsh_pkg::ST_FOLD: begin
				cmd.fold = 1'b1;
			end
			sbsh_pkg::ST_DONE: begin
				cmd.finish = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbsh_pkg::ST_IDLE;
			ret_q <= sbsh_pkg::ST_IDLE;
			round_q <= '0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			if (state_q == sbsh_pkg::ST_COMP) begin
				round_q <= round_q + 1'b1;
			end else begin
				round_q <= '0;
			end
		end
	end

	`SBSH_ASSERT_NEXT(a_comp_ends_in_fold, (state_q == sbsh_pkg::ST_COMP) && (round_q == sbsh_pkg::ROUND_LAST), state_q == sbsh_pkg::ST_FOLD, "compression did not fold after the last round")
	`SBSH_ASSERT_NOW(a_len_in_tail, state_q == sbsh_pkg::ST_PAD_LEN, sts.fill[5:3] == 3'b111, "length bytes outside the block tail")
	`SBSH_ASSERT_NOW(a_done_block_empty, state_q == sbsh_pkg::ST_DONE, sts.fill == '0, "digest ready with a partly filled block")
	`SBSH_ASSERT_NEXT(a_start_round_zero, cmd.comp_start, (state_q == sbsh_pkg::ST_COMP) && (round_q == '0), "compression did not start at round zero")

endmodule

`default_nettype wire

@@ sv/sbsh_datapath.sv @@
`default_nettype none

module sbsh_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [7:0]                      in_byte,
	input  wire sbsh_pkg::cmd_t                  cmd,
	output sbsh_pkg::sts_t                       sts,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [sbsh_pkg::DIGEST_W-1:0]        out_data
);

	logic [sbsh_pkg::BLOCK_W-1:0] blk_q;
	logic [31:0] work_q [8];
	logic [31:0] chain_q [8];
	logic [sbsh_pkg::FILL_W-1:0] fill_q;
	logic [sbsh_pkg::COUNT_W-1:0] count_q;
	logic out_valid_q;
	logic [sbsh_pkg::DIGEST_W-1:0] out_data_q;

	logic [63:0] len_bits;
	logic [63:0] len_shifted;
	logic [7:0] byte_d;
	logic [31:0] w0, w1, w9, w14, w_new;
	logic [31:0] t1, t2;
	logic [31:0] ch, maj;

	assign len_bits = {count_q, 3'b000};
	assign len_shifted = len_bits >> {~fill_q[2:0], 3'b000};

	always_comb begin
		case (cmd.byte_sel)
			sbsh_pkg::SEL_MSG:  byte_d = in_byte;
			sbsh_pkg::SEL_MARK: byte_d = sbsh_pkg::PAD_BYTE;
			sbsh_pkg::SEL_ZERO: byte_d = 8'h00;
			sbsh_pkg::SEL_LEN:  byte_d = len_shifted[7:0];
			default:            byte_d = 8'h00;
		endcase
	end

	assign w0 = blk_q[511:480];
	assign w1 = blk_q[479:448];
	assign w9 = blk_q[223:192];
	assign w14 = blk_q[63:32];
	assign w_new = sbsh_pkg::small_sigma1(w14) + w9 + sbsh_pkg::small_sigma0(w1) + w0;

	assign ch = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
	assign t1 = work_q[7] + sbsh_pkg::big_sigma1(work_q[4]) + ch
		+ sbsh_pkg::ROUND_K[cmd.round] + w0;
	assign t2 = sbsh_pkg::big_sigma0(work_q[0]) + maj;

	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			blk_q <= {blk_q[sbsh_pkg::BLOCK_W-9:0], byte_d};
		end else if (cmd.round_en) begin
			blk_q <= {blk_q[sbsh_pkg::BLOCK_W-33:0], w_new};
		end
		if (cmd.comp_start) begin
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= chain_q[i];
			end
		end else if (cmd.round_en) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
		if (cmd.finish) begin
			for (int i = 0; i < 4; i++) begin
				out_data_q[64*i +: 64] <= {chain_q[2*i], chain_q[2*i+1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= sbsh_pkg::INIT_WORDS[i];
			end
			fill_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fold) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + work_q[i];
				end
			end else if (cmd.finish) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= sbsh_pkg::INIT_WORDS[i];
				end
			end
			if (cmd.finish) begin
				fill_q <= '0;
				count_q <= '0;
			end else begin
				if (cmd.shift_en) begin
					fill_q <= fill_q + 1'b1;
				end
				if (cmd.count_byte) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.fill = fill_q;
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

`default_nettype wire

@@ sv/sha256_byte_stream_hasher_unit.sv @@
// Channel  Direction  Payload
// s_*      in         tdata: msg_byte; tuser: byte_present; tlast: end_of_message
// m_*      out        tdata: digest_word0 .. digest_word3, lowest word first
//
// Message bytes are taken while the unit is idle; each full 64-byte block then holds the
// input while the single round unit runs all rounds and then folds the result.
// An end of message pads one byte per cycle while no block is compressed, with a pause before the length bytes,
// runs one or two more compressions, folds the last one and then loads the digest register once it is free.
// Reset gives the initial chaining values and an empty block at once.
// The digest register holds a result until taken, while the next message streams in.
`default_nettype none

module sha256_byte_stream_hasher_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,  // [7:0] msg_byte
	input  wire logic         s_tuser,  // [0] byte_present
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [255:0]      m_tdata   // digest_word0 [63:0] up to digest_word3 [255:192]
);

	sbsh_pkg::cmd_t cmd;
	sbsh_pkg::sts_t sts;

	sbsh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_present (s_tuser),
		.in_last    (s_tlast),
		.in_ready   (s_tready),
		.sts        (sts),
		.cmd        (cmd)
	);

	sbsh_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ITEM_GOAL = 1950;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned DRAIN_CYCLES = 300;
	localparam int unsigned LONG_HOLD = 1500;
	localparam int unsigned MAX_REPORTS = 10;

	localparam bit [31:0] SHA_H0 [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam bit [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam int unsigned EDGE_LENGTHS [12] = '{
		55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128, 129
	};

	class digest_scoreboard;
		bit [31:0] chain [8];
		bit [7:0] blk [64];
		bit [5:0] fill;
		bit [63:0] bit_count;
		logic [255:0] digest_q [$];
		int unsigned failures;
		int unsigned digest_index;

		function new();
			failures = 0;
			digest_index = 0;
			restart();
		endfunction

		function void restart();
			int i;
			for (i = 0; i < 8; i++) begin
				chain[i] = SHA_H0[i];
			end
			fill = '0;
			bit_count = '0;
		endfunction

		function bit [31:0] rotr(bit [31:0] x, int unsigned n);
			bit [63:0] twice;
			twice = {x, x} >> n;
			return twice[31:0];
		endfunction

		function void compress();
			bit [31:0] w [64];
			bit [31:0] v [8];
			bit [31:0] s0, s1, t1, t2;
			int i;
			for (i = 0; i < 16; i++) begin
				w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
			end
			for (i = 16; i < 64; i++) begin
				s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = w[i-16] + s0 + w[i-7] + s1;
			end
			for (i = 0; i < 8; i++) begin
				v[i] = chain[i];
			end
			for (i = 0; i < 64; i++) begin
				t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
				t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (i = 0; i < 8; i++) begin
				chain[i] += v[i];
			end
		endfunction

		function void note_input(bit [7:0] data, bit present, bit last);
			bit [63:0] total;
			int pos;
			int i;
			if (present) begin
				blk[fill] = data;
				fill++;
				if (fill == 0) begin
					compress();
					bit_count += 64'd512;
				end
			end
			if (!last) begin
				return;
			end
			total = bit_count + 64'(fill) * 64'd8;
			pos = fill;
			blk[pos] = 8'h80;
			pos++;
			if (pos > 56) begin
				while (pos < 64) begin
					blk[pos] = 8'h00;
					pos++;
				end
				compress();
				pos = 0;
			end
			while (pos < 56) begin
				blk[pos] = 8'h00;
				pos++;
			end
			for (i = 0; i < 8; i++) begin
				blk[63-i] = total[8*i +: 8];
			end
			compress();
			digest_q.push_back({chain[6], chain[7], chain[4], chain[5],
				chain[2], chain[3], chain[0], chain[1]});
			restart();
		endfunction

		function void check_result(logic [255:0] got);
			logic [255:0] want;
			int w;
			if (digest_q.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS) begin
					$display("unexpected digest %h", got);
				end
				return;
			end
			want = digest_q.pop_front();
			for (w = 0; w < 4; w++) begin
				if (got[64*w +: 64] !== want[64*w +: 64]) begin
					failures++;
					if (failures <= MAX_REPORTS) begin
						$display("digest %0d word%0d: expected %h, got %h",
							digest_index, w, want[64*w +: 64], got[64*w +: 64]);
					end
				end
			end
			digest_index++;
		endfunction

		function int unsigned pending();
			return digest_q.size();
		endfunction

		function void flush_leftover();
			if (digest_q.size() != 0) begin
				failures += digest_q.size();
				$display("%0d expected digests never arrived", digest_q.size());
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [255:0] m_tdata;

	digest_scoreboard sb;
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	int unsigned messages_sent = 0;
	int unsigned hold_request = 0;
	bit src_eager = 1'b0;

	sha256_byte_stream_hasher_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_input(s_tdata, s_tuser, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata);
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin
		int unsigned gap;
		int unsigned held;
		bit sink_eager;
		sink_eager = 1'b0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 7) == 0) begin
				sink_eager = ~sink_eager;
			end
			if (hold_request != 0) begin
				m_tready <= 1'b0;
				held = 0;
				while (held < hold_request) begin
					@(negedge clk);
					held++;
				end
				hold_request = 0;
			end
			gap = sink_eager ? 0 : $urandom_range(0, 16);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	task automatic send_item(input logic [7:0] data, input logic present, input logic last);
		int unsigned gap;
		gap = src_eager ? 0 : $urandom_range(0, 16);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= present;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (last) begin
			messages_sent++;
		end
	endtask

	task automatic send_message(input int unsigned len, input bit end_on_byte);
		int unsigned i;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				send_item(8'($urandom), 1'b0, 1'b0);
			end
			send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
		end
		if (!end_on_byte || len == 0) begin
			send_item(8'($urandom), 1'b0, 1'b1);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic int unsigned pick_length();
		int unsigned r;
		r = $urandom_range(0, 39);
		if (r < 16) begin
			return $urandom_range(0, 8);
		end else if (r < 27) begin
			return EDGE_LENGTHS[$urandom_range(0, 11)];
		end else if (r < 39) begin
			return $urandom_range(0, 140);
		end
		return $urandom_range(180, 260);
	endfunction

	initial begin
		int unsigned n;
		sb = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message, then "abc", then a byte that also ends its message, then messages ended by items with no byte.
		send_item(8'h5a, 1'b0, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'ha5, 1'b0, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h7f, 1'b1, 1'b0);
		send_item(8'h01, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hff, 1'b0, 1'b1);
		wait_drained();

		while (items_sent < ITEM_GOAL) begin
			src_eager = ($urandom_range(0, 3) == 0);
			if (messages_sent == 12 && hold_request == 0) begin
				hold_request = LONG_HOLD;
				src_eager = 1'b1;
				for (n = 0; n < 8; n++) begin
					send_message($urandom_range(0, 8), 1'($urandom_range(0, 1)));
				end
			end else if (messages_sent == 25) begin
				wait_drained();
				send_message(pick_length(), 1'($urandom_range(0, 1)));
			end else begin
				send_message(pick_length(), 1'($urandom_range(0, 1)));
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.flush_leftover();
		if (sb.failures == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
